@@ rtl/core/gss_pkg.sv @@
package gss_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W = $clog2(CORDIC_STEPS);

  localparam int POS_W  = 24;
  localparam int DIFF_W = POS_W + 1;
  localparam int VEC_W  = DIFF_W + 3;
  localparam int ANG_W  = 24;
  localparam int HEAD_W = 16;
  localparam int MAG_W  = HEAD_W + 1;
  localparam int MUL_W  = DIFF_W + 1;
  localparam int PROD_W = 2 * POS_W + 1;
  localparam int ACC_W  = PROD_W + 1;
  localparam int PC_W   = 4;

  localparam int GAIN_W   = 8;
  localparam int LIMIT_W  = 15;
  localparam int RADIUS_W = 16;
  localparam int THR_W    = 10;
  localparam int BRAKE_W  = 14;
  localparam int CNT_W    = 32;
  localparam int PHASE_W  = 2;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 16;

  localparam int ROUND_HALF = 128;
  localparam logic [ANG_W-1:0] ANG_HALF_TURN = ANG_W'(1 << (ANG_W - 1));
  localparam logic [THR_W-1:0] THROTTLE_MAX = THR_W'(1000);

  // multiplier operand select
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_DX   = 3'd1;
  localparam logic [2:0] MUL_DY   = 3'd2;
  localparam logic [2:0] MUL_SLOW = 3'd3;
  localparam logic [2:0] MUL_TOL  = 3'd4;
  localparam logic [2:0] MUL_ERR  = 3'd5;

  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  localparam logic [1:0] CMP_NONE = 2'd0;
  localparam logic [1:0] CMP_SLOW = 2'd1;
  localparam logic [1:0] CMP_TOL  = 2'd2;

  // conditions under which the sequencer holds its step
  localparam logic [1:0] STAY_NONE        = 2'd0;
  localparam logic [1:0] STAY_NO_INPUT    = 2'd1;
  localparam logic [1:0] STAY_CORDIC_MORE = 2'd2;
  localparam logic [1:0] STAY_OUT_BUSY    = 2'd3;

  localparam logic [IDX_W-1:0] REG_STEER_GAIN    = 3'd0;
  localparam logic [IDX_W-1:0] REG_STEER_LIMIT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SLOW_RADIUS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ARRIVE_TOL    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CRUISE_THR    = 3'd4;
  localparam logic [IDX_W-1:0] REG_APPROACH_BRK  = 3'd5;
  localparam logic [IDX_W-1:0] REG_STOP_BRK      = 3'd6;

  localparam logic [PHASE_W-1:0] PHASE_CRUISE   = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_APPROACH = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_STOP     = 2'd2;

  typedef struct packed {
    logic [PC_W-1:0] next_pc;
    logic [1:0]      stay;
    logic [2:0]      mul_sel;
    logic [1:0]      acc_op;
    logic [1:0]      cmp_op;
    logic            load;
    logic            cordic_en;
    logic            err_en;
    logic            emit;
  } ctrl_t;

  typedef struct packed {
    logic in_go;
    logic cordic_more;
    logic out_busy;
  } stat_t;

  // arctangent of 2^-k in binary angle units, 2^24 units per full turn
  function automatic logic [ANG_W-1:0] atan_step(input logic [4:0] k);
    logic [ANG_W-1:0] a;
    unique case (k)
      5'd0:    a = 24'd2097152;
      5'd1:    a = 24'd1238021;
      5'd2:    a = 24'd654136;
      5'd3:    a = 24'd332050;
      5'd4:    a = 24'd166669;
      5'd5:    a = 24'd83416;
      5'd6:    a = 24'd41718;
      5'd7:    a = 24'd20860;
      5'd8:    a = 24'd10430;
      5'd9:    a = 24'd5215;
      5'd10:   a = 24'd2608;
      5'd11:   a = 24'd1304;
      5'd12:   a = 24'd652;
      5'd13:   a = 24'd326;
      5'd14:   a = 24'd163;
      5'd15:   a = 24'd81;
      5'd16:   a = 24'd41;
      5'd17:   a = 24'd20;
      5'd18:   a = 24'd10;
      5'd19:   a = 24'd5;
      5'd20:   a = 24'd3;
      5'd21:   a = 24'd1;
      5'd22:   a = 24'd1;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/gss_cordic.sv @@
module gss_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic                                step_en,
  input  logic signed [gss_pkg::DIFF_W-1:0]   dx,
  input  logic signed [gss_pkg::DIFF_W-1:0]   dy,
  output logic        [gss_pkg::HEAD_W-1:0]   bearing,
  output logic                                last
);
  import gss_pkg::*;

  logic signed [VEC_W-1:0] x;
  logic signed [VEC_W-1:0] y;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  logic        [ANG_W-1:0] z;
  logic        [ANG_W-1:0] z_rnd;
  logic        [ITER_W-1:0] iter;
  logic                    y_pos;

  always_comb begin
    xs    = x >>> iter;
    ys    = y >>> iter;
    y_pos = !y[VEC_W-1] && (y != '0);
    z_rnd = z + ANG_W'(ROUND_HALF);
    bearing = z_rnd[ANG_W-1 -: HEAD_W];
    last  = (iter == ITER_W'(CORDIC_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (load) begin
      iter <= '0;
    end else if (step_en) begin
      iter <= iter + ITER_W'(1);
    end
  end

  // vectoring mode: left half-plane is folded over first
  always_ff @(posedge clk) begin
    if (load) begin
      if (dx[DIFF_W-1]) begin
        x <= -VEC_W'(dx);
        y <= -VEC_W'(dy);
        z <= ANG_HALF_TURN;
      end else begin
        x <= VEC_W'(dx);
        y <= VEC_W'(dy);
        z <= '0;
      end
    end else if (step_en) begin
      if (y_pos) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_step(5'(iter));
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_step(5'(iter));
      end
    end
  end

endmodule

@@ rtl/core/gss_seq.sv @@
module gss_seq (
  input  logic            clk,
  input  logic            rst,
  input  gss_pkg::stat_t  stat,
  output gss_pkg::ctrl_t  ctrl
);
  import gss_pkg::*;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] addr);
    ctrl_t w;
    w = '0;
    unique case (addr)
      4'd0: begin
        w.load = 1'b1;
        w.stay = STAY_NO_INPUT;
        w.next_pc = 4'd1;
      end
      4'd1: begin
        w.mul_sel = MUL_DX;
        w.cordic_en = 1'b1;
        w.next_pc = 4'd2;
      end
      4'd2: begin
        w.mul_sel = MUL_DY;
        w.acc_op = ACC_LOAD;
        w.cordic_en = 1'b1;
        w.next_pc = 4'd3;
      end
      4'd3: begin
        w.mul_sel = MUL_SLOW;
        w.acc_op = ACC_ADD;
        w.cordic_en = 1'b1;
        w.next_pc = 4'd4;
      end
      4'd4: begin
        w.mul_sel = MUL_TOL;
        w.cmp_op = CMP_SLOW;
        w.cordic_en = 1'b1;
        w.next_pc = 4'd5;
      end
      4'd5: begin
        w.cmp_op = CMP_TOL;
        w.cordic_en = 1'b1;
        w.next_pc = 4'd6;
      end
      4'd6: begin
        w.cordic_en = 1'b1;
        w.stay = STAY_CORDIC_MORE;
        w.next_pc = 4'd7;
      end
      4'd7: begin
        w.err_en = 1'b1;
        w.next_pc = 4'd8;
      end
      4'd8: begin
        w.mul_sel = MUL_ERR;
        w.next_pc = 4'd9;
      end
      4'd9: begin
        w.emit = 1'b1;
        w.stay = STAY_OUT_BUSY;
        w.next_pc = 4'd0;
      end
      default: begin
        w.next_pc = 4'd0;
      end
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            hold;

  always_comb begin
    ctrl = ucode(pc);
    unique case (ctrl.stay)
      STAY_NONE:        hold = 1'b0;
      STAY_NO_INPUT:    hold = !stat.in_go;
      STAY_CORDIC_MORE: hold = stat.cordic_more;
      STAY_OUT_BUSY:    hold = stat.out_busy;
      default:          hold = 1'b0;
    endcase
    pc_next = hold ? pc : ctrl.next_pc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/core/goal_seek_steering_controller_unit.sv @@
// goal seeking steering controller
//
// input channel: in_valid/in_stall carries one pose sample (goal_x, goal_y,
// pos_x, pos_y, heading). a transaction happens when in_valid is high and
// in_stall is low. in_stall is low only while the sequencer waits for work
// and out of reset, so one sample is processed at a time.
// output channel: out_valid/out_stall carries one drive command per sample.
// processing: 16 cordic steps, with the squaring and radius compares riding
// along, then 3 steering/output steps. the load step that waits for input
// comes before these, so a new sample is taken only after the command for
// the previous one has been handed to the output register.
// the output register holds a finished command while out_stall is high; the
// sequencer waits at its last step until that register frees up, and in
// the meantime the next sample is not taken.
// config: cfg_valid/cfg_ready writes register cfg_index with cfg_data;
// cfg_ready is high outside reset, unknown indexes are ignored.
// reset (rst, synchronous): config registers return to defaults, the
// approach flag clears, command counter clears, out_valid drops.
module goal_seek_steering_controller_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [gss_pkg::POS_W-1:0]     goal_x,
  input  logic signed [gss_pkg::POS_W-1:0]     goal_y,
  input  logic signed [gss_pkg::POS_W-1:0]     pos_x,
  input  logic signed [gss_pkg::POS_W-1:0]     pos_y,
  input  logic signed [gss_pkg::HEAD_W-1:0]    heading,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [gss_pkg::CNT_W-1:0]     command_index,
  output logic signed [gss_pkg::HEAD_W-1:0]    steering,
  output logic        [gss_pkg::THR_W-1:0]     throttle,
  output logic        [gss_pkg::BRAKE_W-1:0]   brake,
  output logic        [gss_pkg::PHASE_W-1:0]   phase,
  output logic                                 goal_reached,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [gss_pkg::IDX_W-1:0]     cfg_index,
  input  logic        [gss_pkg::DATA_W-1:0]    cfg_data
);
  import gss_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  logic [GAIN_W-1:0]   steer_gain;
  logic [LIMIT_W-1:0]  steer_limit;
  logic [RADIUS_W-1:0] slow_radius;
  logic [RADIUS_W-1:0] arrive_tolerance;
  logic [THR_W-1:0]    cruise_throttle;
  logic [BRAKE_W-1:0]  approach_brake;
  logic [BRAKE_W-1:0]  stop_brake;

  logic signed [DIFF_W-1:0] dx_in;
  logic signed [DIFF_W-1:0] dy_in;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic        [HEAD_W-1:0] head;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] product;
  logic        [PROD_W-1:0]  prod;
  logic        [ACC_W-1:0]   acc;
  logic                      near_slow;
  logic                      near_tol;

  logic [HEAD_W-1:0] bearing;
  logic              cordic_last;
  logic [HEAD_W-1:0] err_u;
  logic              err_neg;
  logic [MAG_W-1:0]  mag;

  logic [HEAD_W+8-1:0] rnd;
  logic [HEAD_W-1:0]   q;
  logic [HEAD_W-1:0]   q_cl;
  logic [HEAD_W-1:0]   steer_val;
  logic [THR_W-1:0]    thr_cl;

  logic approaching;
  logic [CNT_W-1:0] command_count;
  logic out_busy;
  logic load_go;
  logic emit;
  logic appr_now;
  logic stop_now;

  assign cfg_ready = !rst;
  assign in_stall  = rst || !ctrl.load;
  assign out_busy  = out_valid && out_stall;
  assign load_go   = ctrl.load && in_valid;
  assign emit      = ctrl.emit && !out_busy;

  assign stat.in_go       = in_valid;
  assign stat.cordic_more = !cordic_last;
  assign stat.out_busy    = out_busy;

  gss_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  gss_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .load    (load_go),
    .step_en (ctrl.cordic_en),
    .dx      (dx_in),
    .dy      (dy_in),
    .bearing (bearing),
    .last    (cordic_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_gain       <= GAIN_W'(128);
      steer_limit      <= LIMIT_W'(5215);
      slow_radius      <= RADIUS_W'(1500);
      arrive_tolerance <= RADIUS_W'(500);
      cruise_throttle  <= THR_W'(200);
      approach_brake   <= BRAKE_W'(300);
      stop_brake       <= BRAKE_W'(8000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEER_GAIN:   steer_gain       <= cfg_data[GAIN_W-1:0];
        REG_STEER_LIMIT:  steer_limit      <= cfg_data[LIMIT_W-1:0];
        REG_SLOW_RADIUS:  slow_radius      <= cfg_data[RADIUS_W-1:0];
        REG_ARRIVE_TOL:   arrive_tolerance <= cfg_data[RADIUS_W-1:0];
        REG_CRUISE_THR:   cruise_throttle  <= cfg_data[THR_W-1:0];
        REG_APPROACH_BRK: approach_brake   <= cfg_data[BRAKE_W-1:0];
        REG_STOP_BRK:     stop_brake       <= cfg_data[BRAKE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dx_in = DIFF_W'(goal_x) - DIFF_W'(pos_x);
    dy_in = DIFF_W'(goal_y) - DIFF_W'(pos_y);
  end

  // shared multiplier, operands picked by the control word
  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_DX: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      MUL_DY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      MUL_SLOW: begin
        mul_a = {{(MUL_W-RADIUS_W){1'b0}}, slow_radius};
        mul_b = {{(MUL_W-RADIUS_W){1'b0}}, slow_radius};
      end
      MUL_TOL: begin
        mul_a = {{(MUL_W-RADIUS_W){1'b0}}, arrive_tolerance};
        mul_b = {{(MUL_W-RADIUS_W){1'b0}}, arrive_tolerance};
      end
      MUL_ERR: begin
        mul_a = {{(MUL_W-MAG_W){1'b0}}, mag};
        mul_b = {{(MUL_W-GAIN_W){1'b0}}, steer_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    product = mul_a * mul_b;
  end

  always_comb begin
    err_u = bearing - head;
    rnd   = {1'b0, prod[HEAD_W+8-2:0]} + (HEAD_W+8)'(ROUND_HALF);
    q     = rnd[HEAD_W+8-1:8];
    q_cl  = (q > {1'b0, steer_limit}) ? {1'b0, steer_limit} : q;
    steer_val = err_neg ? -q_cl : q_cl;
    thr_cl    = (cruise_throttle > THROTTLE_MAX) ? THROTTLE_MAX : cruise_throttle;
    appr_now  = approaching || near_slow;
    stop_now  = appr_now && near_tol;
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      dx   <= dx_in;
      dy   <= dy_in;
      head <= heading;
    end
    if (ctrl.mul_sel != MUL_NONE) begin
      prod <= product[PROD_W-1:0];
    end
    unique case (ctrl.acc_op)
      ACC_LOAD: acc <= ACC_W'(prod);
      ACC_ADD:  acc <= acc + ACC_W'(prod);
      default: ;
    endcase
    unique case (ctrl.cmp_op)
      CMP_SLOW: near_slow <= (acc <= ACC_W'(prod));
      CMP_TOL:  near_tol  <= (acc <= ACC_W'(prod));
      default: ;
    endcase
    if (ctrl.err_en) begin
      err_neg <= err_u[HEAD_W-1];
      mag     <= err_u[HEAD_W-1] ? (MAG_W'(0) - {1'b1, err_u}) : {1'b0, err_u};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      approaching   <= 1'b0;
      command_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (emit) begin
        out_valid     <= 1'b1;
        approaching   <= appr_now && !stop_now;
        command_count <= command_count + CNT_W'(1);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      command_index <= command_count;
      if (stop_now) begin
        steering     <= '0;
        throttle     <= '0;
        brake        <= stop_brake;
        phase        <= PHASE_STOP;
        goal_reached <= 1'b1;
      end else if (appr_now) begin
        steering     <= steer_val;
        throttle     <= '0;
        brake        <= approach_brake;
        phase        <= PHASE_APPROACH;
        goal_reached <= 1'b0;
      end else begin
        steering     <= steer_val;
        throttle     <= thr_cl;
        brake        <= '0;
        phase        <= PHASE_CRUISE;
        goal_reached <= 1'b0;
      end
    end
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("command not presented after emit");

  a_stop_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && goal_reached) |-> (phase == PHASE_STOP && steering == '0 && throttle == '0))
    else $error("stop command carries steering or throttle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    emit |=> (command_count == $past(command_count) + CNT_W'(1)))
    else $error("command counter did not advance by one");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second sample taken while one is in flight");

endmodule
